// ===== rtl/core/lbf_pkg.sv =====
package lbf_pkg;

  // Fixed field widths of the frame and the result.
  localparam int HOST_W = 8;
  localparam int PORT_W = 3;
  localparam int CNT_W  = 4;
  localparam int MASK_W = 8;
  localparam int ID_W   = 8;

  // Every host number a frame can carry.
  localparam int HOST_SPAN = 1 << HOST_W;

  localparam int NUM_PORTS_DEF = 8;
  localparam int NUM_HOSTS_DEF = 256;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIDGE_ID    = 2'd0,
    CFG_PORTS_IN_USE = 2'd1,
    CFG_BLOCKED_MASK = 2'd2
  } lbf_cfg_reg_e;

  typedef enum logic {
    B_IDLE,
    B_FLOOD
  } lbf_back_state_e;

  typedef struct packed {
    logic [ID_W-1:0]   bridge_id;
    logic [CNT_W-1:0]  ports_in_use;
    logic [MASK_W-1:0] blocked_mask;
  } lbf_cfg_t;

  // One classified frame on its way from the lookup stage to the sequencer.
  typedef struct packed {
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
    logic [PORT_W-1:0] ingress;
    logic              flood;
    logic [PORT_W-1:0] port;
  } lbf_entry_t;

endpackage

// ===== rtl/core/lbf_ram.sv =====
module lbf_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lbf_front.sv =====
module lbf_front import lbf_pkg::*; #(
  parameter int NUM_HOSTS = NUM_HOSTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [HOST_W-1:0] source_host_i,
  input  logic [HOST_W-1:0] destination_host_i,
  input  logic [PORT_W-1:0] ingress_port_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output lbf_entry_t        push_entry_o
);

  // Only host numbers a frame can carry ever reach the table.
  localparam int TBL_DEPTH = (NUM_HOSTS < HOST_SPAN) ? NUM_HOSTS : HOST_SPAN;
  localparam int IDX_W     = $clog2(TBL_DEPTH);

  logic [IDX_W-1:0]     idx_tbl [HOST_SPAN];
  logic [IDX_W-1:0]     src_idx;
  logic [IDX_W-1:0]     dst_idx;
  logic [TBL_DEPTH-1:0] known_q, known_d;
  logic                 accept;
  logic                 drop;
  logic [PORT_W-1:0]    rd_port;

  logic              s1_valid_q, s1_valid_d;
  logic              hit_q;
  logic              same_q;
  logic [HOST_W-1:0] src_q;
  logic [HOST_W-1:0] dst_q;
  logic [PORT_W-1:0] ingress_q;

  for (genvar h = 0; h < HOST_SPAN; h++) begin : g_idx
    assign idx_tbl[h] = IDX_W'(h % TBL_DEPTH);
  end

  assign src_idx = idx_tbl[source_host_i];
  assign dst_idx = idx_tbl[destination_host_i];

  // The source is learned at the accepting edge; the destination lookup reads the
  // port table at that same edge, so a shared entry is resolved by same_q instead.
  lbf_ram #(
    .WIDTH(PORT_W),
    .DEPTH(TBL_DEPTH)
  ) u_port_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(src_idx),
    .wdata_i(ingress_port_i),
    .re_i   (accept),
    .raddr_i(dst_idx),
    .rdata_o(rd_port)
  );

  // A known destination on the ingress port produces nothing.
  assign drop = s1_valid_q && hit_q && (same_q || (rd_port == ingress_q));

  assign in_stall_o   = s1_valid_q && !drop && !push_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = s1_valid_q && !drop;

  always_comb begin
    push_entry_o.src     = src_q;
    push_entry_o.dst     = dst_q;
    push_entry_o.ingress = ingress_q;
    push_entry_o.flood   = !hit_q;
    push_entry_o.port    = rd_port;
  end

  always_comb begin
    known_d = known_q;
    if (accept) begin
      known_d[src_idx] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (drop || (push_valid_o && push_ready_i)) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      known_q    <= known_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q     <= source_host_i;
      dst_q     <= destination_host_i;
      ingress_q <= ingress_port_i;
      same_q    <= (src_idx == dst_idx);
      hit_q     <= known_q[dst_idx] || (src_idx == dst_idx);
    end
  end

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && !push_ready_i)
    else $error("front stalls without a held item");

  a_accept_learns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q && known_q[$past(src_idx)])
    else $error("accepted item did not learn its source");

endmodule

// ===== rtl/core/lbf_queue.sv =====
module lbf_queue import lbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  lbf_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output lbf_entry_t pop_entry_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  lbf_entry_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_QW'(QUEUE_DEPTH))
    else $error("queue holds more items than it has slots");

endmodule

// ===== rtl/core/lbf_back.sv =====
module lbf_back import lbf_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbf_cfg_t          cfg_i,
  input  logic              q_valid_i,
  input  lbf_entry_t        q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PORT_W-1:0] egress_port_o,
  output logic [HOST_W-1:0] out_source_host_o,
  output logic [HOST_W-1:0] out_destination_host_o,
  output logic [ID_W-1:0]   sending_bridge_o,
  output logic              last_o
);

  lbf_back_state_e state_q, state_d;
  logic [NUM_PORTS-1:0] elig;
  logic [NUM_PORTS-1:0] rem_q, rem_d;
  logic [NUM_PORTS-1:0] low;
  logic [NUM_PORTS-1:0] rem_after;
  logic [PORT_W-1:0]    low_idx;
  logic                 out_adv;
  logic                 emit;
  logic [PORT_W-1:0]    emit_port;
  logic                 emit_last;

  logic              out_valid_q, out_valid_d;
  logic [PORT_W-1:0] egress_q;
  logic [HOST_W-1:0] src_q;
  logic [HOST_W-1:0] dst_q;
  logic [ID_W-1:0]   bridge_q;
  logic              last_q;

  // Ports a flood may use: attached, not blocked and not the ingress port.
  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_elig
    logic blk;
    if (p < MASK_W) begin : g_mask
      assign blk = cfg_i.blocked_mask[p];
    end else begin : g_open
      assign blk = 1'b0;
    end
    assign elig[p] = (CNT_W'(p) < cfg_i.ports_in_use) && !blk &&
                     (CNT_W'(p) != CNT_W'(q_entry_i.ingress));
  end

  assign low       = rem_q & (~rem_q + 1'b1);
  assign rem_after = rem_q & ~low;
  assign out_adv   = !out_valid_q || !out_stall_i;

  always_comb begin
    low_idx = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (low[p]) begin
        low_idx = low_idx | PORT_W'(p);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && q_entry_i.flood && (elig != '0)) begin
          state_d = B_FLOOD;
          rem_d   = elig;
        end
      end
      B_FLOOD: begin
        if (out_adv) begin
          rem_d = rem_after;
          if (rem_after == '0) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_port = q_entry_i.port;
    emit_last = 1'b1;
    q_pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (!q_entry_i.flood) begin
            emit    = out_adv;
            q_pop_o = out_adv;
          end else if (elig == '0) begin
            q_pop_o = 1'b1;
          end
        end
      end
      B_FLOOD: begin
        emit      = out_adv;
        emit_port = low_idx;
        emit_last = (rem_after == '0);
        q_pop_o   = out_adv && (rem_after == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      egress_q <= emit_port;
      src_q    <= q_entry_i.src;
      dst_q    <= q_entry_i.dst;
      bridge_q <= cfg_i.bridge_id;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign egress_port_o          = egress_q;
  assign out_source_host_o      = src_q;
  assign out_destination_host_o = dst_q;
  assign sending_bridge_o       = bridge_q;
  assign last_o                 = last_q;

  a_flood_has_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_FLOOD |-> rem_q != '0 && q_valid_i)
    else $error("flood in progress with no port left or no item held");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && emit |-> emit_last)
    else $error("item released before its last copy");

endmodule

// ===== rtl/core/learning_bridge_forward_top.sv =====
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o   source_host, destination_host, ingress_port
// out       output     out_valid_o / out_stall_i egress_port, out_source/destination_host,
//                                                sending_bridge, last
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The lookup stage is registered, as is the read of the host-port RAM; while the
// queue has room a new item is taken every cycle.
// The sequencer sends a known destination straight from the queue head; a flood
// first loads its port set and then sends one copy per eligible port, lowest first.
// Reset clears the host-known bits at once; there is no clearing pass.
// A stall on the output holds the result register and backs up through the queue.
module learning_bridge_forward_top import lbf_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  parameter int NUM_HOSTS = NUM_HOSTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [HOST_W-1:0]     source_host_i,
  input  logic [HOST_W-1:0]     destination_host_i,
  input  logic [PORT_W-1:0]     ingress_port_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_W-1:0]     egress_port_o,
  output logic [HOST_W-1:0]     out_source_host_o,
  output logic [HOST_W-1:0]     out_destination_host_o,
  output logic [ID_W-1:0]       sending_bridge_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  lbf_cfg_t   cfg_q, cfg_d;
  logic       push_valid;
  logic       push_ready;
  lbf_entry_t push_entry;
  logic       q_valid;
  logic       q_pop;
  lbf_entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BRIDGE_ID:    cfg_d.bridge_id    = cfg_data_i[ID_W-1:0];
        CFG_PORTS_IN_USE: cfg_d.ports_in_use = cfg_data_i[CNT_W-1:0];
        CFG_BLOCKED_MASK: cfg_d.blocked_mask = cfg_data_i[MASK_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bridge_id    <= '0;
      cfg_q.ports_in_use <= CNT_W'(8);
      cfg_q.blocked_mask <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbf_front #(
    .NUM_HOSTS(NUM_HOSTS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .source_host_i     (source_host_i),
    .destination_host_i(destination_host_i),
    .ingress_port_i    (ingress_port_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_entry_o      (push_entry)
  );

  lbf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_entry_o (q_entry)
  );

  lbf_back #(
    .NUM_PORTS(NUM_PORTS)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .q_valid_i             (q_valid),
    .q_entry_i             (q_entry),
    .q_pop_o               (q_pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .egress_port_o         (egress_port_o),
    .out_source_host_o     (out_source_host_o),
    .out_destination_host_o(out_destination_host_o),
    .sending_bridge_o      (sending_bridge_o),
    .last_o                (last_o)
  );

endmodule

// ===== tb/learning_bridge_forward_checker.sv =====
module learning_bridge_forward_checker import lbf_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  parameter int NUM_HOSTS = NUM_HOSTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [HOST_W-1:0]     source_host_i,
  input  logic [HOST_W-1:0]     destination_host_i,
  input  logic [PORT_W-1:0]     ingress_port_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [PORT_W-1:0]     egress_port_i,
  input  logic [HOST_W-1:0]     out_source_host_i,
  input  logic [HOST_W-1:0]     out_destination_host_i,
  input  logic [ID_W-1:0]       sending_bridge_i,
  input  logic                  last_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           frames_o,
  output int unsigned           floods_o,
  output int unsigned           copies_o
);

  typedef struct packed {
    logic [PORT_W-1:0] egress;
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
    logic [ID_W-1:0]   bridge;
    logic              last;
  } frame_copy_t;

  logic              host_known [NUM_HOSTS];
  logic [PORT_W-1:0] host_port  [NUM_HOSTS];
  logic [ID_W-1:0]   bridge_id_q;
  logic [CNT_W-1:0]  ports_q;
  logic [MASK_W-1:0] blocked_q;

  frame_copy_t expected_copies [$];
  int unsigned mismatches = 0;
  int unsigned frames = 0;
  int unsigned floods = 0;
  int unsigned copies = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] bridge copy %0d: %s", $time, copies, what);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Learns the source, then queues the copies this frame should produce.
  function automatic void forward_frame(input logic [HOST_W-1:0] src,
                                        input logic [HOST_W-1:0] dst,
                                        input logic [PORT_W-1:0] ing);
    int si;
    int di;
    int reach;
    int n;
    frame_copy_t c;
    si = int'(src) % NUM_HOSTS;
    di = int'(dst) % NUM_HOSTS;
    host_known[si] = 1'b1;
    host_port[si]  = ing;
    c.src    = src;
    c.dst    = dst;
    c.bridge = bridge_id_q;
    c.last   = 1'b1;
    c.egress = '0;
    if (host_known[di]) begin
      // A destination behind the ingress port is filtered.
      if (host_port[di] != ing) begin
        c.egress = host_port[di];
        expected_copies.push_back(c);
      end
      return;
    end
    floods++;
    reach = (int'(ports_q) > NUM_PORTS) ? NUM_PORTS : int'(ports_q);
    n = 0;
    c.last = 1'b0;
    for (int p = 0; p < reach; p++) begin
      if (!(p < MASK_W && blocked_q[p]) && p != int'(ing)) begin
        c.egress = p[PORT_W-1:0];
        expected_copies.push_back(c);
        n++;
      end
    end
    if (n > 0) begin
      expected_copies[expected_copies.size()-1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_copy_t want;
    if (!rst_ni) begin
      for (int h = 0; h < NUM_HOSTS; h++) begin
        host_known[h] = 1'b0;
      end
      bridge_id_q = '0;
      ports_q     = CNT_W'(NUM_PORTS_DEF);
      blocked_q   = '0;
      expected_copies.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (lbf_cfg_reg_e'(cfg_index_i))
          CFG_BRIDGE_ID:    bridge_id_q = cfg_data_i[ID_W-1:0];
          CFG_PORTS_IN_USE: ports_q     = cfg_data_i[CNT_W-1:0];
          CFG_BLOCKED_MASK: blocked_q   = cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        copies++;
        if (expected_copies.size() == 0) begin
          report_mismatch($sformatf("unexpected copy on port %0d", egress_port_i));
        end else begin
          want = expected_copies.pop_front();
          check_field("egress_port", 8'(egress_port_i), 8'(want.egress));
          check_field("out_source_host", out_source_host_i, want.src);
          check_field("out_destination_host", out_destination_host_i, want.dst);
          check_field("sending_bridge", sending_bridge_i, want.bridge);
          check_field("last", 8'(last_i), 8'(want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        frames++;
        forward_frame(source_host_i, destination_host_i, ingress_port_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_copies.size();
    frames_o     <= frames;
    floods_o     <= floods;
    copies_o     <= copies;
  end

endmodule

// ===== tb/learning_bridge_forward_top_tb.sv =====
module learning_bridge_forward_top_tb;
  import lbf_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int DRAIN_CYCLES      = 16;
  localparam int HOLD_CYCLES       = 200;
  localparam int SEGMENTS          = 8;
  localparam int ITEMS_PER_SEGMENT = 53;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [HOST_W-1:0]     source_host_i = '0;
  logic [HOST_W-1:0]     destination_host_i = '0;
  logic [PORT_W-1:0]     ingress_port_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PORT_W-1:0]     egress_port_o;
  logic [HOST_W-1:0]     out_source_host_o;
  logic [HOST_W-1:0]     out_destination_host_o;
  logic [ID_W-1:0]       sending_bridge_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_BRIDGE_ID;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames;
  int unsigned floods;
  int unsigned copies;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 76;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  bit          learned [HOST_SPAN];

  logic [ID_W-1:0]   seg_id    [SEGMENTS] = '{8'h00, 8'hFF, 8'hA5, 8'h3C,
                                              8'h81, 8'h7E, 8'h12, 8'hC3};
  logic [CNT_W-1:0]  seg_ports [SEGMENTS] = '{4'd8, 4'd1, 4'd4, 4'd0,
                                              4'd15, 4'd9, 4'd2, 4'd8};
  logic [MASK_W-1:0] seg_mask  [SEGMENTS] = '{8'h00, 8'hFF, 8'h5A, 8'h00,
                                              8'h24, 8'hF0, 8'h01, 8'h0F};

  learning_bridge_forward_top DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .source_host_i          (source_host_i),
    .destination_host_i     (destination_host_i),
    .ingress_port_i         (ingress_port_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .egress_port_o          (egress_port_o),
    .out_source_host_o      (out_source_host_o),
    .out_destination_host_o (out_destination_host_o),
    .sending_bridge_o       (sending_bridge_o),
    .last_o                 (last_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  learning_bridge_forward_checker bridge_check (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .source_host_i          (source_host_i),
    .destination_host_i     (destination_host_i),
    .ingress_port_i         (ingress_port_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .egress_port_i          (egress_port_o),
    .out_source_host_i      (out_source_host_o),
    .out_destination_host_i (out_destination_host_o),
    .sending_bridge_i       (sending_bridge_o),
    .last_i                 (last_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .fail_count_o           (fail_count),
    .pending_o              (pending),
    .frames_o               (frames),
    .floods_o               (floods),
    .copies_o               (copies)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off whenever the stimulus
  // flips hold_toggle, so the bridge backs up into its input.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_frame(input logic [HOST_W-1:0] src, input logic [HOST_W-1:0] dst,
                            input logic [PORT_W-1:0] ing);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    source_host_i      <= src;
    destination_host_i <= dst;
    ingress_port_i     <= ing;
    do @(posedge clk_i); while (in_stall_o);
    learned[src] = 1'b1;
  endtask

  // Wait until every copy has left and the pipeline has emptied.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input lbf_cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_registers(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] ports,
                                 input logic [MASK_W-1:0] mask);
    settle();
    put_reg(CFG_BRIDGE_ID, CFG_DATA_W'(id));
    put_reg(CFG_PORTS_IN_USE, CFG_DATA_W'(ports));
    put_reg(CFG_BLOCKED_MASK, CFG_DATA_W'(mask));
    cfg_valid_i <= 1'b0;
  endtask

  // A small set of hosts at both ends of the range, so entries get relearned.
  function automatic logic [HOST_W-1:0] pool_host();
    int k;
    k = $urandom_range(15);
    return (k < 8) ? HOST_W'(k) : HOST_W'(k + 240);
  endfunction

  task automatic random_frame();
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
    int pick;
    int tries;
    pick = $urandom_range(99);
    src = (pick < 65) ? pool_host() : HOST_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Look for a host not seen yet so the frame floods.
      tries = 0;
      dst = HOST_W'($urandom);
      while (learned[dst] && tries < 32) begin
        dst = HOST_W'($urandom);
        tries++;
      end
    end else if (pick < 70) begin
      dst = pool_host();
    end else if (pick < 80) begin
      dst = src;
    end else begin
      dst = HOST_W'($urandom);
    end
    send_frame(src, dst, PORT_W'($urandom_range(7)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: bridge 0, all eight ports, nothing blocked.
    send_frame(8'h00, 8'hFF, 3'd0);
    send_frame(8'hFF, 8'h00, 3'd7);
    send_frame(8'h00, 8'hFF, 3'd0);
    send_frame(8'h55, 8'h55, 3'd3);
    send_frame(8'hAA, 8'h55, 3'd3);
    send_frame(8'h55, 8'hAA, 3'd5);
    send_frame(8'h0F, 8'h55, 3'd2);
    send_frame(8'hF0, 8'h0F, 3'd7);

    // Three ports, port 1 blocked; the first frame arrives on an unattached port.
    write_registers(8'hFF, 4'd3, 8'h02);
    send_frame(8'h10, 8'h80, 3'd6);
    send_frame(8'h11, 8'h81, 3'd0);
    send_frame(8'h12, 8'h82, 3'd2);

    // No eligible flood port; known copies still go to blocked or unattached ports.
    write_registers(8'h01, 4'd3, 8'h06);
    send_frame(8'h13, 8'h83, 3'd0);
    send_frame(8'h14, 8'h10, 3'd0);
    send_frame(8'h15, 8'h12, 3'd1);

    write_registers(8'h80, 4'd0, 8'h00);
    send_frame(8'h16, 8'h84, 3'd4);
    send_frame(8'h17, 8'h16, 3'd0);

    write_registers(8'h5A, 4'd15, 8'hFF);
    send_frame(8'h18, 8'h85, 3'd3);
    send_frame(8'h19, 8'h18, 3'd1);

    for (int s = 0; s < SEGMENTS; s++) begin
      write_registers(seg_id[s], seg_ports[s], seg_mask[s]);
      if (s < 3) begin
        send_idle_pct = 35;
        recv_idle_pct <= 76;
      end else if (s < 6) begin
        send_idle_pct = 76;
        recv_idle_pct <= 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (s == 0 || s == 6) begin
        hold_toggle <= ~hold_toggle;
      end
      for (int i = 0; i < ITEMS_PER_SEGMENT; i++) begin
        random_frame();
      end
    end

    settle();
    $display("Run covered %0d frames, %0d of them flooded, and %0d forwarded copies,",
             frames, floods, copies);
    $display("over eight random bridge settings, three idle patterns and two long hold-offs.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
